// ===== rtl/core/uep0_pkg.sv =====
package uep0_pkg;

  // Fixed sizes of the endpoint and of the descriptor set.
  localparam logic [6:0]  EP0_SIZE        = 7'd8;
  localparam logic [15:0] DEVICE_DESC_LEN = 16'd18;
  localparam logic [7:0]  STRING_COUNT    = 8'd8;

  typedef enum logic [1:0] {
    OP_OUT_DONE  = 2'd0,
    OP_IN_DONE   = 2'd1,
    OP_BUS_RESET = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    STAGE_SETUP    = 2'd0,
    STAGE_DATA_OUT = 2'd1,
    STAGE_DATA_IN  = 2'd2
  } stage_t;

  typedef enum logic [1:0] {
    DS_POWERED    = 2'd0,
    DS_DEFAULT    = 2'd1,
    DS_ADDRESSED  = 2'd2,
    DS_CONFIGURED = 2'd3
  } dev_state_t;

  typedef enum logic [1:0] {
    CFG_SELF_POWERED     = 2'd0,
    CFG_CONFIG_DESC_LEN  = 2'd1,
    CFG_STRING_DESC_LENS = 2'd2
  } cfg_index_t;

  localparam logic [3:0] PID_SETUP = 4'hD;

  // Standard request codes.
  localparam logic [7:0] REQ_GET_STATUS        = 8'd0;
  localparam logic [7:0] REQ_CLEAR_FEATURE     = 8'd1;
  localparam logic [7:0] REQ_SET_FEATURE       = 8'd3;
  localparam logic [7:0] REQ_SET_ADDR          = 8'd5;
  localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'd6;
  localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
  localparam logic [7:0] REQ_GET_INTERFACE     = 8'd10;
  localparam logic [7:0] REQ_SET_INTERFACE     = 8'd11;

  localparam logic [7:0] RTYPE_STD_DEVICE_IN = 8'h80;

  localparam logic [4:0] RECIP_DEVICE    = 5'd0;
  localparam logic [4:0] RECIP_INTERFACE = 5'd1;
  localparam logic [4:0] RECIP_ENDPOINT  = 5'd2;

  localparam logic [7:0] DESC_DEVICE    = 8'd1;
  localparam logic [7:0] DESC_CONFIG    = 8'd2;
  localparam logic [7:0] DESC_STRING    = 8'd3;
  localparam logic [7:0] DESC_QUALIFIER = 8'd6;

  localparam logic [7:0] FEAT_ENDPOINT_HALT = 8'd0;
  localparam logic [7:0] FEAT_REMOTE_WAKE   = 8'd1;

  // Chunk sources.
  localparam logic [3:0] SRC_NONE        = 4'd0;
  localparam logic [3:0] SRC_DEVICE      = 4'd1;
  localparam logic [3:0] SRC_CONFIG      = 4'd2;
  localparam logic [3:0] SRC_STATUS_WORD = 4'd3;
  localparam logic [3:0] SRC_CONFIG_VAL  = 4'd4;

  // Buffer descriptor status bytes.
  localparam logic [7:0] BD_IDLE      = 8'h00;
  localparam logic [7:0] BD_OWN       = 8'h80;
  localparam logic [7:0] BD_STALL     = 8'h84;
  localparam logic [7:0] BD_ARM_DATA0 = 8'h88;
  localparam logic [7:0] BD_ARM_DATA1 = 8'hC8;

  localparam logic [7:0] HALT_SET       = 8'h84;
  localparam logic [7:0] HALT_CLEAR_OUT = 8'h88;
  localparam logic [7:0] HALT_CLEAR_IN  = 8'h00;

  // One input beat, first field in the lowest bits.
  typedef struct packed {
    logic        in_toggle;
    logic        out_toggle;
    logic [9:0]  out_byte_count;
    logic [15:0] length_word;
    logic [15:0] index_word;
    logic [15:0] value_word;
    logic [7:0]  request_code;
    logic [7:0]  request_type;
    logic [3:0]  out_pid;
  } item_t;

  // One result beat, first field in the lowest bits, zero padded to 88 bits.
  typedef struct packed {
    logic [4:0]  pad;
    logic        stalled;
    dev_state_t  device_state;
    logic [6:0]  bus_address;
    logic [7:0]  halt_value;
    logic [4:0]  halt_target;
    logic        halt_write;
    logic [15:0] status_word;
    logic [15:0] chunk_offset;
    logic [3:0]  chunk_source;
    logic [6:0]  in_chunk_length;
    logic [7:0]  ep0_in_status;
    logic [7:0]  ep0_out_status;
  } result_t;

  typedef struct packed {
    logic        self_powered;
    logic [15:0] config_desc_length;
    logic [63:0] string_desc_lengths;
  } cfg_t;

  typedef struct packed {
    dev_state_t  dev_state;
    stage_t      stage;
    logic [15:0] bytes_left;
    logic [15:0] send_offset;
    logic [3:0]  send_source;
    logic [15:0] reply_word;
    logic        remote_wake;
    logic [7:0]  active_config;
    logic [6:0]  pending_address;
    logic [6:0]  current_address;
    logic [31:0] halt_marks;
    logic [7:0]  out_bd;
    logic [7:0]  in_bd;
  } state_t;

endpackage

// ===== rtl/core/uep0_step.sv =====
module uep0_step (
  input  uep0_pkg::opcode_t op,
  input  uep0_pkg::item_t   item,
  input  uep0_pkg::state_t  st,
  input  uep0_pkg::cfg_t    cfg,
  output uep0_pkg::state_t  nx,
  output uep0_pkg::result_t res
);

  always_comb begin
    logic        handled;
    logic        arm;
    logic [15:0] arm_left;
    logic [6:0]  n;
    logic [4:0]  recip;
    logic [7:0]  dtype;
    logic [7:0]  idx;
    logic [7:0]  feat;
    logic [3:0]  num;
    logic        dir;
    logic [4:0]  target;

    nx       = st;
    res      = '0;
    handled  = 1'b0;
    arm      = 1'b0;
    arm_left = st.bytes_left;
    n        = '0;
    recip    = item.request_type[4:0];
    dtype    = item.value_word[15:8];
    idx      = item.value_word[7:0];
    feat     = item.value_word[7:0];
    num      = item.index_word[3:0];
    dir      = item.index_word[7];
    target   = {num, dir};

    case (op)
      uep0_pkg::OP_OUT_DONE: begin
        if (item.out_pid == uep0_pkg::PID_SETUP) begin
          nx.stage       = uep0_pkg::STAGE_SETUP;
          nx.bytes_left  = '0;
          nx.send_offset = '0;
          nx.send_source = uep0_pkg::SRC_NONE;
          if (item.request_type[6:5] == 2'b00) begin
            case (item.request_code)
              uep0_pkg::REQ_SET_ADDR: begin
                handled            = 1'b1;
                nx.dev_state       = uep0_pkg::DS_ADDRESSED;
                nx.pending_address = item.value_word[6:0];
              end
              uep0_pkg::REQ_GET_DESCRIPTOR: begin
                if (item.request_type == uep0_pkg::RTYPE_STD_DEVICE_IN) begin
                  case (dtype)
                    uep0_pkg::DESC_DEVICE: begin
                      handled        = 1'b1;
                      nx.send_source = uep0_pkg::SRC_DEVICE;
                      nx.bytes_left  = uep0_pkg::DEVICE_DESC_LEN;
                    end
                    uep0_pkg::DESC_CONFIG: begin
                      handled        = 1'b1;
                      nx.send_source = uep0_pkg::SRC_CONFIG;
                      nx.bytes_left  = cfg.config_desc_length;
                    end
                    uep0_pkg::DESC_STRING: begin
                      if (idx < uep0_pkg::STRING_COUNT) begin
                        handled        = 1'b1;
                        nx.send_source = {1'b1, idx[2:0]};
                        nx.bytes_left  =
                          {8'd0, cfg.string_desc_lengths[{idx[2:0], 3'b000} +: 8]};
                      end
                    end
                    uep0_pkg::DESC_QUALIFIER: handled = 1'b1;
                    default: handled = 1'b0;
                  endcase
                end
              end
              uep0_pkg::REQ_SET_CONFIGURATION: begin
                handled          = 1'b1;
                nx.active_config = item.value_word[7:0];
                nx.dev_state     = (item.value_word[7:0] != 8'd0) ?
                                   uep0_pkg::DS_CONFIGURED : uep0_pkg::DS_ADDRESSED;
              end
              uep0_pkg::REQ_GET_CONFIGURATION: begin
                handled        = 1'b1;
                nx.send_source = uep0_pkg::SRC_CONFIG_VAL;
                nx.reply_word  = {8'd0, st.active_config};
                nx.bytes_left  = 16'd1;
              end
              uep0_pkg::REQ_GET_STATUS: begin
                handled = 1'b1;
                if (recip == uep0_pkg::RECIP_DEVICE) begin
                  nx.reply_word = {14'd0, st.remote_wake, cfg.self_powered};
                end else if (recip == uep0_pkg::RECIP_INTERFACE) begin
                  nx.reply_word = '0;
                end else if (recip == uep0_pkg::RECIP_ENDPOINT) begin
                  nx.reply_word = {15'd0, st.halt_marks[target]};
                end else begin
                  handled = 1'b0;
                end
                if (handled) begin
                  nx.send_source = uep0_pkg::SRC_STATUS_WORD;
                  nx.bytes_left  = 16'd2;
                end
              end
              uep0_pkg::REQ_CLEAR_FEATURE, uep0_pkg::REQ_SET_FEATURE: begin
                if (recip == uep0_pkg::RECIP_DEVICE) begin
                  if (feat == uep0_pkg::FEAT_REMOTE_WAKE) begin
                    handled        = 1'b1;
                    nx.remote_wake = (item.request_code == uep0_pkg::REQ_SET_FEATURE);
                  end
                end else if (recip == uep0_pkg::RECIP_ENDPOINT) begin
                  // Endpoint zero cannot be halted or cleared this way.
                  if (feat == uep0_pkg::FEAT_ENDPOINT_HALT && num != 4'd0) begin
                    handled         = 1'b1;
                    res.halt_write  = 1'b1;
                    res.halt_target = target;
                    if (item.request_code == uep0_pkg::REQ_SET_FEATURE) begin
                      res.halt_value            = uep0_pkg::HALT_SET;
                      nx.halt_marks[target]     = 1'b1;
                    end else begin
                      res.halt_value            = dir ? uep0_pkg::HALT_CLEAR_IN :
                                                        uep0_pkg::HALT_CLEAR_OUT;
                      nx.halt_marks[target]     = 1'b0;
                    end
                  end
                end
              end
              uep0_pkg::REQ_GET_INTERFACE: begin
                handled        = 1'b1;
                nx.send_source = uep0_pkg::SRC_STATUS_WORD;
                nx.reply_word  = '0;
                nx.bytes_left  = 16'd1;
              end
              uep0_pkg::REQ_SET_INTERFACE: handled = 1'b1;
              default: handled = 1'b0;
            endcase
          end

          if (!handled) begin
            nx.bytes_left  = '0;
            nx.send_source = uep0_pkg::SRC_NONE;
            nx.out_bd      = uep0_pkg::BD_STALL;
            nx.in_bd       = uep0_pkg::BD_STALL;
            res.stalled    = 1'b1;
          end else if (item.request_type[7]) begin
            // Device-to-host reply: clip to wLength and arm the first chunk.
            arm      = 1'b1;
            arm_left = (item.length_word < nx.bytes_left) ? item.length_word :
                                                            nx.bytes_left;
            nx.stage  = uep0_pkg::STAGE_DATA_IN;
            nx.out_bd = uep0_pkg::BD_OWN;
            nx.in_bd  = uep0_pkg::BD_ARM_DATA1;
          end else begin
            nx.bytes_left  = '0;
            nx.send_source = uep0_pkg::SRC_NONE;
            nx.stage       = uep0_pkg::STAGE_DATA_OUT;
            nx.out_bd      = uep0_pkg::BD_ARM_DATA1;
            nx.in_bd       = uep0_pkg::BD_ARM_DATA1;
          end
        end else if (st.stage == uep0_pkg::STAGE_DATA_OUT) begin
          nx.out_bd = item.out_toggle ? uep0_pkg::BD_ARM_DATA0 : uep0_pkg::BD_ARM_DATA1;
        end else begin
          nx.stage  = uep0_pkg::STAGE_SETUP;
          nx.out_bd = uep0_pkg::BD_ARM_DATA0;
          nx.in_bd  = uep0_pkg::BD_IDLE;
        end
      end

      uep0_pkg::OP_IN_DONE: begin
        // The new address takes effect after the status stage of the address request.
        if (st.current_address == 7'd0 && st.dev_state == uep0_pkg::DS_ADDRESSED) begin
          nx.current_address = st.pending_address;
          if (st.pending_address == 7'd0) begin
            nx.dev_state = uep0_pkg::DS_DEFAULT;
          end
        end
        if (st.stage == uep0_pkg::STAGE_DATA_IN) begin
          arm      = 1'b1;
          arm_left = st.bytes_left;
          nx.in_bd = item.in_toggle ? uep0_pkg::BD_ARM_DATA0 : uep0_pkg::BD_ARM_DATA1;
        end else begin
          nx.stage  = uep0_pkg::STAGE_SETUP;
          nx.out_bd = uep0_pkg::BD_ARM_DATA0;
          nx.in_bd  = uep0_pkg::BD_IDLE;
        end
      end

      uep0_pkg::OP_BUS_RESET: begin
        nx.current_address = '0;
        nx.pending_address = '0;
        nx.stage           = uep0_pkg::STAGE_SETUP;
        nx.out_bd          = uep0_pkg::BD_ARM_DATA0;
        nx.in_bd           = uep0_pkg::BD_IDLE;
        nx.bytes_left      = '0;
        nx.send_offset     = '0;
        nx.send_source     = uep0_pkg::SRC_NONE;
        nx.reply_word      = '0;
        nx.remote_wake     = 1'b0;
        nx.active_config   = '0;
        nx.halt_marks      = '0;
        nx.dev_state       = uep0_pkg::DS_DEFAULT;
      end

      default: nx = st;
    endcase

    if (arm) begin
      n = (arm_left < {9'd0, uep0_pkg::EP0_SIZE}) ? arm_left[6:0] : uep0_pkg::EP0_SIZE;
      nx.bytes_left       = arm_left - {9'd0, n};
      res.in_chunk_length = n;
      res.chunk_source    = nx.send_source;
      res.chunk_offset    = nx.send_offset;
      nx.send_offset      = nx.send_offset + {9'd0, n};
    end

    if (res.chunk_source == uep0_pkg::SRC_STATUS_WORD ||
        res.chunk_source == uep0_pkg::SRC_CONFIG_VAL) begin
      res.status_word = nx.reply_word;
    end
    res.ep0_out_status = nx.out_bd;
    res.ep0_in_status  = nx.in_bd;
    res.bus_address    = nx.current_address;
    res.device_state   = nx.dev_state;
  end

endmodule

// ===== rtl/core/usb_ep0_control_transfer.sv =====
// Channel   Direction  Handshake           Beat contents
// s_axis    in         s_tvalid/s_tready   one finished EP0 transaction or bus reset
// m_axis    out        m_tvalid/m_tready   one result per input beat
// cfg       in         cfg_we              register write, no read-back
//
// An input beat is held in an input register and is processed in the cycle it
// leaves that register, landing in the result register.
// One beat per cycle is sustained while the output does not stall; the
// combinational update of the control state between them sets that rate.
// Reset is synchronous and active high; it returns the control state and the
// configuration registers to their reset values.
// A stalled output holds the result register, and the input register then fills
// and deasserts s_tready until the result is taken.
module usb_ep0_control_transfer (
  input  logic        clk,
  input  logic        rst,
  // Input beats.
  input  logic        s_tvalid,
  output logic        s_tready,
  // out_pid, request_type, request_code, value_word, index_word, length_word,
  // out_byte_count, out_toggle, in_toggle (80 bits).
  input  logic [79:0] s_tdata,
  // opcode.
  input  logic [1:0]  s_tuser,
  // Result beats.
  output logic        m_tvalid,
  input  logic        m_tready,
  // ep0_out_status, ep0_in_status, in_chunk_length, chunk_source, chunk_offset,
  // status_word, halt_write, halt_target, halt_value, bus_address,
  // device_state, stalled, then five zero bits.
  output logic [87:0] m_tdata,
  // Configuration writes.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic                in_valid;
  uep0_pkg::opcode_t   in_op;
  uep0_pkg::item_t     in_item;
  uep0_pkg::state_t    st;
  uep0_pkg::state_t    st_next;
  uep0_pkg::cfg_t      cfg;
  uep0_pkg::result_t   res_next;
  uep0_pkg::result_t   res;
  logic                advance;

  // The held beat moves on whenever the result register is empty or draining.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tdata  = res;

  uep0_step u_step (
    .op   (in_op),
    .item (in_item),
    .st   (st),
    .cfg  (cfg),
    .nx   (st_next),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
      st       <= '0;
      cfg.self_powered        <= 1'b0;
      cfg.config_desc_length  <= 16'd9;
      cfg.string_desc_lengths <= '0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        st       <= st_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          uep0_pkg::CFG_SELF_POWERED:     cfg.self_powered        <= cfg_data[0];
          uep0_pkg::CFG_CONFIG_DESC_LEN:  cfg.config_desc_length  <= cfg_data[15:0];
          uep0_pkg::CFG_STRING_DESC_LENS: cfg.string_desc_lengths <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op   <= uep0_pkg::opcode_t'(s_tuser);
      in_item <= uep0_pkg::item_t'(s_tdata);
    end
    if (advance) begin
      res <= res_next;
    end
  end

endmodule
